// File: sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define BFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define BFA_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: sv/bfa_pkg.sv
// Shared types and codes of the best-fit block allocator.
// No dependencies; the interfaces and the allocator unit import this package.
`default_nettype none

package bfa_pkg;

  localparam int NODE_COUNT_DEF = 64;

  localparam int KIND_W   = 2;
  localparam int REQ_W    = 25;
  localparam int HANDLE_W = 6;
  localparam int ADDR_W   = 24;
  localparam int SIZE_W   = 25;
  localparam int STATUS_W = 3;
  localparam int TAG_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 25;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REINIT = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_DESC   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

  localparam logic [TAG_W-1:0] TAG_UNUSED = 2'd0;
  localparam logic [TAG_W-1:0] TAG_FREE   = 2'd1;
  localparam logic [TAG_W-1:0] TAG_ALLOC  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 1'b1;

  // Select bit of the link memory address: next and prev halves.
  localparam logic LSEL_NEXT = 1'b0;
  localparam logic LSEL_PREV = 1'b1;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = '0;
  localparam logic [SIZE_W-1:0] HEAP_SIZE_RST = 25'h1000000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage

`default_nettype wire

// File: sv/bfa_in_if.sv
// Request channel of the allocator: valid/ready and one request beat.
// Depends on bfa_pkg for field widths.
`default_nettype none

interface bfa_in_if;
  import bfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [REQ_W-1:0]    request_size;
  logic [HANDLE_W-1:0] handle_in;
  logic [ADDR_W-1:0]   lookup_address;

  modport source (output valid, kind, request_size, handle_in, lookup_address,
                  input ready);
  modport sink (input valid, kind, request_size, handle_in, lookup_address,
                output ready);
endinterface

`default_nettype wire

// File: sv/bfa_out_if.sv
// Result channel of the allocator: valid/ready and one result beat.
// Depends on bfa_pkg for field widths.
`default_nettype none

interface bfa_out_if;
  import bfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle_out;
  logic [ADDR_W-1:0]   block_address;
  logic [SIZE_W-1:0]   block_size;

  modport source (output valid, status, handle_out, block_address, block_size,
                  input ready);
  modport sink (input valid, status, handle_out, block_address, block_size,
                output ready);
endinterface

`default_nettype wire

// File: sv/bfa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

`default_nettype wire

// File: sv/best_fit_block_allocator_unit.sv
// Channel   | Dir | Beat contents
// in_ch     | in  | kind, request_size, handle_in, lookup_address
// out_ch    | out | status, handle_out, block_address, block_size
// cfg_*     | in  | write enable, register index, write data (no handshake)
// Both memories have registered read data, so a list walk issues a read and
// then consumes its result for each node visited. Allocate walks the free list
// (a second time when it splits); free scans the free list for neighbors and
// walks it again to reinsert the merged block; lookup reads each descriptor
// in turn.
// After reset, and for a reinitialize, a sweep rebuilds the lists while
// in_ch.ready stays low. A waiting result does not block the next request;
// a finished result waits only for the output register.
`default_nettype none
`include "assert_macros.svh"

module best_fit_block_allocator_unit #(
  parameter int NODE_COUNT = bfa_pkg::NODE_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bfa_in_if.sink                           in_ch,
  bfa_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [bfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bfa_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);
  localparam int LW = $clog2(NODE_COUNT + 3);
  localparam int SZW = SIZE_W + 1;
  localparam logic [LW-1:0] HEAD_ALLOC  = LW'(NODE_COUNT);
  localparam logic [LW-1:0] HEAD_FREE   = LW'(NODE_COUNT + 1);
  localparam logic [LW-1:0] HEAD_UNUSED = LW'(NODE_COUNT + 2);
  localparam logic [LW-1:0] LAST_NODE   = LW'(NODE_COUNT - 1);
  localparam logic [IW-1:0] LAST_IDX    = IW'(NODE_COUNT - 1);

  localparam logic [5:0] S_SWEEP = 6'd0;
  localparam logic [5:0] S_IDLE  = 6'd1;
  localparam logic [5:0] S_RESP  = 6'd2;
  localparam logic [5:0] S_UN0   = 6'd3;
  localparam logic [5:0] S_UN1   = 6'd4;
  localparam logic [5:0] S_UN2   = 6'd5;
  localparam logic [5:0] S_UN3   = 6'd6;
  localparam logic [5:0] S_LK0   = 6'd7;
  localparam logic [5:0] S_LK1   = 6'd8;
  localparam logic [5:0] S_LK2   = 6'd9;
  localparam logic [5:0] S_LK3   = 6'd10;
  localparam logic [5:0] S_LK4   = 6'd11;
  localparam logic [5:0] S_LK5   = 6'd12;
  localparam logic [5:0] S_WK0   = 6'd13;
  localparam logic [5:0] S_WK1   = 6'd14;
  localparam logic [5:0] S_A0    = 6'd15;
  localparam logic [5:0] S_A1    = 6'd16;
  localparam logic [5:0] S_A2    = 6'd17;
  localparam logic [5:0] S_A3    = 6'd18;
  localparam logic [5:0] S_A4    = 6'd19;
  localparam logic [5:0] S_A5    = 6'd20;
  localparam logic [5:0] S_A6    = 6'd21;
  localparam logic [5:0] S_A7    = 6'd22;
  localparam logic [5:0] S_A8    = 6'd23;
  localparam logic [5:0] S_A9    = 6'd24;
  localparam logic [5:0] S_F0    = 6'd25;
  localparam logic [5:0] S_F1    = 6'd26;
  localparam logic [5:0] S_F2    = 6'd27;
  localparam logic [5:0] S_F3    = 6'd28;
  localparam logic [5:0] S_F4    = 6'd29;
  localparam logic [5:0] S_F5    = 6'd30;
  localparam logic [5:0] S_F6    = 6'd31;
  localparam logic [5:0] S_F7    = 6'd32;
  localparam logic [5:0] S_F8    = 6'd33;
  localparam logic [5:0] S_F9    = 6'd34;
  localparam logic [5:0] S_F10   = 6'd35;
  localparam logic [5:0] S_F11   = 6'd36;
  localparam logic [5:0] S_F12   = 6'd37;
  localparam logic [5:0] S_F13   = 6'd38;
  localparam logic [5:0] S_L0    = 6'd39;
  localparam logic [5:0] S_L1    = 6'd40;

  // Control registers.
  logic [5:0]       state_r, state_nxt, ret_r, ret_nxt;
  logic             reinit_r, reinit_nxt;
  logic [LW:0]      cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] cfg_base_r, cfg_base_nxt, pb_r, pb_nxt;
  logic [SIZE_W-1:0] cfg_size_r, cfg_size_nxt, ps_r, ps_nxt;

  // Working registers.
  logic [SZW-1:0]    sz_r, sz_nxt, key_r, key_nxt;
  logic [IW-1:0]     h_r, h_nxt, idx_r, idx_nxt;
  logic [ADDR_W-1:0] lk_addr_r, lk_addr_nxt;
  logic [LW-1:0]     cur_r, cur_nxt, s_r, s_nxt;
  logic              back_r, back_nxt, after_r, after_nxt;
  logic [LW-1:0]     sub_i_r, sub_i_nxt, sub_p_r, sub_p_nxt, sub_n_r, sub_n_nxt;
  logic [ADDR_W-1:0] w_addr_r, w_addr_nxt, a0_r, a0_nxt, nda_r, nda_nxt, la_r, la_nxt;
  logic [SIZE_W-1:0] w_size_r, w_size_nxt, s0_r, s0_nxt, nds_r, nds_nxt;
  logic [SIZE_W-1:0] ls_r, ls_nxt, rs_r, rs_nxt;
  logic [LW-1:0]     nd_r, nd_nxt, m_r, m_nxt, left_r, left_nxt, right_r, right_nxt;
  logic              lf_r, lf_nxt, rf_r, rf_nxt;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt, out_st_r, out_st_nxt;
  logic [HANDLE_W-1:0] res_h_r, res_h_nxt, out_h_r, out_h_nxt;
  logic [ADDR_W-1:0]   res_a_r, res_a_nxt, out_a_r, out_a_nxt;
  logic [SIZE_W-1:0]   res_s_r, res_s_nxt, out_s_r, out_s_nxt;

  // Memory ports.
  logic          ent_we, ent_re;
  logic [IW-1:0] ent_waddr, ent_raddr;
  entry_t        ent_wdata, ent_rdata;
  logic          lnk_we, lnk_re;
  logic [LW:0]   lnk_waddr, lnk_raddr;
  logic [LW-1:0] lnk_wdata, lnk_rdata;

  logic              in_acc;
  logic [LW-1:0]     sw_idx;
  logic [SIZE_W-1:0] scur, ms, trim_size, trim_lim;
  logic [ADDR_W-1:0] trim_base;
  logic              cont, lmatch, rmatch;
  logic [SZW-1:0]    sz_round, lsum, a0_end;

  bfa_ram #(.WIDTH($bits(entry_t)), .DEPTH(NODE_COUNT)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .re(ent_re), .raddr(ent_raddr), .rdata(ent_rdata)
  );

  bfa_ram #(.WIDTH(LW), .DEPTH(2 ** (LW + 1))) u_lnk_ram (
    .clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
    .re(lnk_re), .raddr(lnk_raddr), .rdata(lnk_rdata)
  );

  function automatic logic [LW-1:0] next_init(input logic [LW-1:0] i);
    logic [LW-1:0] v;
    if (i == HEAD_ALLOC) v = HEAD_ALLOC;
    else if (i == HEAD_FREE) v = '0;
    else if (i == HEAD_UNUSED) v = LW'(1);
    else if (i == '0) v = HEAD_FREE;
    else if (i == LAST_NODE) v = HEAD_UNUSED;
    else v = i + LW'(1);
    return v;
  endfunction

  function automatic logic [LW-1:0] prev_init(input logic [LW-1:0] i);
    logic [LW-1:0] v;
    if (i == HEAD_ALLOC) v = HEAD_ALLOC;
    else if (i == HEAD_FREE) v = '0;
    else if (i == HEAD_UNUSED) v = LAST_NODE;
    else if (i == '0) v = HEAD_FREE;
    else if (i == LW'(1)) v = HEAD_UNUSED;
    else v = i - LW'(1);
    return v;
  endfunction

  assign in_ch.ready          = (state_r == S_IDLE);
  assign in_acc               = in_ch.valid && (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.handle_out    = out_h_r;
  assign out_ch.block_address = out_a_r;
  assign out_ch.block_size    = out_s_r;

  // Region trimming for a rebuild: clear low bits and clip at the address space.
  assign trim_base = {cfg_base_r[ADDR_W-1:5], 5'b0};
  assign trim_lim  = HEAP_SIZE_RST - {1'b0, trim_base};
  assign trim_size = ({cfg_size_r[SIZE_W-1:5], 5'b0} > trim_lim) ? trim_lim
                                                                   : {cfg_size_r[SIZE_W-1:5], 5'b0};

  assign sz_round = ({1'b0, in_ch.request_size} + SZW'(31)) & ~SZW'(31);
  assign sw_idx   = cnt_r[LW-1:0];
  assign scur     = (cur_r < HEAD_ALLOC) ? ent_rdata.size : '0;
  assign cont     = back_r ? (key_r < {1'b0, scur})
                           : ((cur_r != HEAD_FREE) && ({1'b0, scur} < key_r));
  assign ms       = s0_r - sz_r[SIZE_W-1:0];
  assign lsum     = {2'b0, ent_rdata.addr} + {1'b0, ent_rdata.size};
  assign a0_end   = {2'b0, a0_r} + {1'b0, s0_r};
  assign lmatch   = (lsum == {2'b0, a0_r});
  assign rmatch   = ({2'b0, ent_rdata.addr} == a0_end);

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;  reinit_nxt = reinit_r;  cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cfg_base_nxt = cfg_base_r;  cfg_size_nxt = cfg_size_r;
    pb_nxt = pb_r;  ps_nxt = ps_r;
    sz_nxt = sz_r;  key_nxt = key_r;  h_nxt = h_r;  idx_nxt = idx_r;
    lk_addr_nxt = lk_addr_r;  cur_nxt = cur_r;  s_nxt = s_r;
    back_nxt = back_r;  after_nxt = after_r;
    sub_i_nxt = sub_i_r;  sub_p_nxt = sub_p_r;  sub_n_nxt = sub_n_r;
    w_addr_nxt = w_addr_r;  w_size_nxt = w_size_r;  a0_nxt = a0_r;  s0_nxt = s0_r;
    nda_nxt = nda_r;  nds_nxt = nds_r;  la_nxt = la_r;  ls_nxt = ls_r;  rs_nxt = rs_r;
    nd_nxt = nd_r;  m_nxt = m_r;  left_nxt = left_r;  right_nxt = right_r;
    lf_nxt = lf_r;  rf_nxt = rf_r;
    res_st_nxt = res_st_r;  res_h_nxt = res_h_r;  res_a_nxt = res_a_r;  res_s_nxt = res_s_r;
    out_st_nxt = out_st_r;  out_h_nxt = out_h_r;  out_a_nxt = out_a_r;  out_s_nxt = out_s_r;

    ent_we = 1'b0;  ent_waddr = '0;  ent_wdata = '0;  ent_re = 1'b0;  ent_raddr = '0;
    lnk_we = 1'b0;  lnk_waddr = '0;  lnk_wdata = '0;  lnk_re = 1'b0;  lnk_raddr = '0;

    if (cfg_we) begin
      if (cfg_index == REG_HEAP_BASE) begin
        cfg_base_nxt = cfg_wdata[ADDR_W-1:0];
      end else begin
        cfg_size_nxt = cfg_wdata[SIZE_W-1:0];
      end
    end

    case (state_r)
      S_SWEEP: begin
        lnk_we    = 1'b1;
        lnk_waddr = cnt_r;
        lnk_wdata = cnt_r[LW] ? prev_init(sw_idx) : next_init(sw_idx);
        if (!cnt_r[LW] && (sw_idx < HEAD_ALLOC)) begin
          ent_we    = 1'b1;
          ent_waddr = sw_idx[IW-1:0];
          ent_wdata = (sw_idx == '0) ? entry_t'{addr: pb_r, size: ps_r, tag: TAG_FREE}
                                     : entry_t'{addr: '0, size: '0, tag: TAG_UNUSED};
        end
        if (sw_idx == HEAD_UNUSED) begin
          if (cnt_r[LW]) begin
            if (reinit_r) begin
              res_st_nxt = ST_OK;  res_h_nxt = '0;  res_a_nxt = pb_r;  res_s_nxt = ps_r;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            cnt_nxt = {1'b1, {LW{1'b0}}};
          end
        end else begin
          cnt_nxt = cnt_r + (LW + 1)'(1);
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          res_st_nxt = ST_OK;  res_h_nxt = '0;  res_a_nxt = '0;  res_s_nxt = '0;
          case (in_ch.kind)
            KIND_ALLOC: begin
              sz_nxt = sz_round;
              if (in_ch.request_size == '0) begin
                res_st_nxt = ST_ZERO_SIZE;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_A0;
              end
            end
            KIND_FREE: begin
              h_nxt = IW'(in_ch.handle_in);
              if (32'(in_ch.handle_in) >= 32'(NODE_COUNT)) begin
                res_st_nxt = ST_BAD_HANDLE;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_F0;
              end
            end
            KIND_LOOKUP: begin
              lk_addr_nxt = in_ch.lookup_address;
              idx_nxt     = '0;
              state_nxt   = S_L0;
            end
            default: begin
              pb_nxt     = trim_base;
              ps_nxt     = trim_size;
              cnt_nxt    = '0;
              reinit_nxt = 1'b1;
              state_nxt  = S_SWEEP;
            end
          endcase
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt = res_st_r;  out_h_nxt = res_h_r;
          out_a_nxt  = res_a_r;   out_s_nxt = res_s_r;
          state_nxt  = S_IDLE;
        end
      end

      // Unlink sub_i: read both links, then patch both neighbors.
      S_UN0: begin
        lnk_re = 1'b1;  lnk_raddr = {LSEL_NEXT, sub_i_r};
        state_nxt = S_UN1;
      end
      S_UN1: begin
        sub_n_nxt = lnk_rdata;
        lnk_re = 1'b1;  lnk_raddr = {LSEL_PREV, sub_i_r};
        state_nxt = S_UN2;
      end
      S_UN2: begin
        sub_p_nxt = lnk_rdata;
        lnk_we = 1'b1;  lnk_waddr = {LSEL_NEXT, lnk_rdata};  lnk_wdata = sub_n_r;
        state_nxt = S_UN3;
      end
      S_UN3: begin
        lnk_we = 1'b1;  lnk_waddr = {LSEL_PREV, sub_n_r};  lnk_wdata = sub_p_r;
        state_nxt = ret_r;
      end

      // Link sub_i between sub_p and sub_n; the missing neighbor is read first.
      S_LK0: begin
        lnk_re    = 1'b1;
        lnk_raddr = after_r ? {LSEL_NEXT, sub_p_r} : {LSEL_PREV, sub_n_r};
        state_nxt = S_LK1;
      end
      S_LK1: begin
        if (after_r) sub_n_nxt = lnk_rdata;
        else sub_p_nxt = lnk_rdata;
        state_nxt = S_LK2;
      end
      S_LK2: begin
        lnk_we = 1'b1;  lnk_waddr = {LSEL_NEXT, sub_i_r};  lnk_wdata = sub_n_r;
        state_nxt = S_LK3;
      end
      S_LK3: begin
        lnk_we = 1'b1;  lnk_waddr = {LSEL_PREV, sub_i_r};  lnk_wdata = sub_p_r;
        state_nxt = S_LK4;
      end
      S_LK4: begin
        lnk_we = 1'b1;  lnk_waddr = {LSEL_PREV, sub_n_r};  lnk_wdata = sub_i_r;
        state_nxt = S_LK5;
      end
      S_LK5: begin
        lnk_we = 1'b1;  lnk_waddr = {LSEL_NEXT, sub_p_r};  lnk_wdata = sub_i_r;
        state_nxt = ret_r;
      end

      // Size-ordered walk from cur: forward while smaller than key, or
      // backward while larger than key.
      S_WK0: begin
        ent_re = 1'b1;  ent_raddr = cur_r[IW-1:0];
        lnk_re = 1'b1;  lnk_raddr = {back_r ? LSEL_PREV : LSEL_NEXT, cur_r};
        state_nxt = S_WK1;
      end
      S_WK1: begin
        w_addr_nxt = ent_rdata.addr;
        w_size_nxt = ent_rdata.size;
        if (cont) begin
          cur_nxt   = lnk_rdata;
          state_nxt = S_WK0;
        end else begin
          state_nxt = ret_r;
        end
      end

      S_A0: begin
        lnk_re = 1'b1;  lnk_raddr = {LSEL_NEXT, HEAD_FREE};
        state_nxt = S_A1;
      end
      S_A1: begin
        cur_nxt = lnk_rdata;  key_nxt = sz_r;  back_nxt = 1'b0;
        ret_nxt = S_A2;  state_nxt = S_WK0;
      end
      S_A2: begin
        if (cur_r == HEAD_FREE) begin
          res_st_nxt = ST_NO_SPACE;
          state_nxt  = S_RESP;
        end else begin
          nd_nxt = cur_r;  a0_nxt = w_addr_r;  s0_nxt = w_size_r;
          if ({1'b0, w_size_r} != sz_r) begin
            lnk_re = 1'b1;  lnk_raddr = {LSEL_NEXT, HEAD_UNUSED};
            state_nxt = S_A3;
          end else begin
            state_nxt = S_A7;
          end
        end
      end
      S_A3: begin
        if (lnk_rdata == HEAD_UNUSED) begin
          res_st_nxt = ST_NO_DESC;
          state_nxt  = S_RESP;
        end else begin
          m_nxt = lnk_rdata;  sub_i_nxt = lnk_rdata;
          ret_nxt = S_A4;  state_nxt = S_UN0;
        end
      end
      S_A4: begin
        // The remainder becomes a new free block right after the allocation.
        ent_we    = 1'b1;
        ent_waddr = m_r[IW-1:0];
        ent_wdata = '{addr: a0_r + sz_r[ADDR_W-1:0], size: ms, tag: TAG_FREE};
        key_nxt   = {1'b0, ms};
        state_nxt = S_A5;
      end
      S_A5: begin
        ent_we    = 1'b1;
        ent_waddr = nd_r[IW-1:0];
        ent_wdata = '{addr: a0_r, size: sz_r[SIZE_W-1:0], tag: TAG_FREE};
        cur_nxt   = nd_r;
        back_nxt  = !(key_r > sz_r);
        ret_nxt   = S_A6;
        state_nxt = S_WK0;
      end
      S_A6: begin
        sub_i_nxt = m_r;
        after_nxt = back_r;
        if (back_r) sub_p_nxt = cur_r;
        else sub_n_nxt = cur_r;
        ret_nxt = S_A7;  state_nxt = S_LK0;
      end
      S_A7: begin
        sub_i_nxt = nd_r;
        ret_nxt = S_A8;  state_nxt = S_UN0;
      end
      S_A8: begin
        sub_i_nxt = nd_r;  sub_p_nxt = HEAD_ALLOC;  after_nxt = 1'b1;
        ret_nxt = S_A9;  state_nxt = S_LK0;
      end
      S_A9: begin
        ent_we    = 1'b1;
        ent_waddr = nd_r[IW-1:0];
        ent_wdata = '{addr: a0_r, size: sz_r[SIZE_W-1:0], tag: TAG_ALLOC};
        res_st_nxt = ST_OK;  res_h_nxt = HANDLE_W'(nd_r);
        res_a_nxt  = a0_r;   res_s_nxt = sz_r[SIZE_W-1:0];
        state_nxt  = S_RESP;
      end

      S_F0: begin
        ent_re = 1'b1;  ent_raddr = h_r;
        state_nxt = S_F1;
      end
      S_F1: begin
        if (ent_rdata.tag != TAG_ALLOC) begin
          res_st_nxt = ST_BAD_HANDLE;
          state_nxt  = S_RESP;
        end else begin
          a0_nxt  = ent_rdata.addr;  s0_nxt  = ent_rdata.size;
          nd_nxt  = LW'(h_r);
          nda_nxt = ent_rdata.addr;  nds_nxt = ent_rdata.size;
          lf_nxt  = 1'b0;  rf_nxt = 1'b0;
          lnk_re = 1'b1;  lnk_raddr = {LSEL_NEXT, HEAD_FREE};
          state_nxt = S_F2;
        end
      end
      S_F2: begin
        s_nxt = lnk_rdata;
        state_nxt = S_F3;
      end
      S_F3: begin
        if (s_r == HEAD_FREE) begin
          state_nxt = S_F5;
        end else begin
          ent_re = 1'b1;  ent_raddr = s_r[IW-1:0];
          lnk_re = 1'b1;  lnk_raddr = {LSEL_NEXT, s_r};
          state_nxt = S_F4;
        end
      end
      S_F4: begin
        // Look for free neighbors ending at, or starting after, the block.
        if (lmatch) begin
          left_nxt = s_r;  la_nxt = ent_rdata.addr;  ls_nxt = ent_rdata.size;
          lf_nxt = 1'b1;
        end else if (rmatch) begin
          right_nxt = s_r;  rs_nxt = ent_rdata.size;
          rf_nxt = 1'b1;
        end
        if ((lf_r || lmatch) && (rf_r || (rmatch && !lmatch))) begin
          state_nxt = S_F5;
        end else begin
          state_nxt = S_F2;
        end
      end
      S_F5: begin
        sub_i_nxt = LW'(h_r);
        ret_nxt = S_F6;  state_nxt = S_UN0;
      end
      S_F6: begin
        if (lf_r) begin
          sub_i_nxt = left_r;
          ret_nxt = S_F7;  state_nxt = S_UN0;
        end else begin
          state_nxt = S_F8;
        end
      end
      S_F7: begin
        ent_we    = 1'b1;
        ent_waddr = h_r;
        ent_wdata = '{addr: a0_r, size: s0_r, tag: TAG_UNUSED};
        nd_nxt  = left_r;  nda_nxt = la_r;  nds_nxt = ls_r + s0_r;
        sub_i_nxt = LW'(h_r);  sub_p_nxt = HEAD_UNUSED;  after_nxt = 1'b1;
        ret_nxt = S_F8;  state_nxt = S_LK0;
      end
      S_F8: begin
        if (rf_r) begin
          sub_i_nxt = right_r;
          ret_nxt = S_F9;  state_nxt = S_UN0;
        end else begin
          state_nxt = S_F10;
        end
      end
      S_F9: begin
        ent_we    = 1'b1;
        ent_waddr = right_r[IW-1:0];
        ent_wdata = '{addr: nda_r, size: rs_r, tag: TAG_UNUSED};
        nds_nxt   = nds_r + rs_r;
        sub_i_nxt = right_r;  sub_p_nxt = HEAD_UNUSED;  after_nxt = 1'b1;
        ret_nxt = S_F10;  state_nxt = S_LK0;
      end
      S_F10: begin
        lnk_re = 1'b1;  lnk_raddr = {LSEL_NEXT, HEAD_FREE};
        state_nxt = S_F11;
      end
      S_F11: begin
        cur_nxt = lnk_rdata;  key_nxt = {1'b0, nds_r};  back_nxt = 1'b0;
        ret_nxt = S_F12;  state_nxt = S_WK0;
      end
      S_F12: begin
        ent_we    = 1'b1;
        ent_waddr = nd_r[IW-1:0];
        ent_wdata = '{addr: nda_r, size: nds_r, tag: TAG_FREE};
        sub_i_nxt = nd_r;  sub_n_nxt = cur_r;  after_nxt = 1'b0;
        ret_nxt = S_F13;  state_nxt = S_LK0;
      end
      S_F13: begin
        res_st_nxt = ST_OK;  res_h_nxt = HANDLE_W'(h_r);
        res_a_nxt  = a0_r;   res_s_nxt = s0_r;
        state_nxt  = S_RESP;
      end

      S_L0: begin
        ent_re = 1'b1;  ent_raddr = idx_r;
        state_nxt = S_L1;
      end
      S_L1: begin
        if (ent_rdata.tag == TAG_ALLOC && ent_rdata.addr == lk_addr_r) begin
          res_st_nxt = ST_OK;  res_h_nxt = HANDLE_W'(idx_r);
          res_a_nxt  = ent_rdata.addr;  res_s_nxt = ent_rdata.size;
          state_nxt  = S_RESP;
        end else if (idx_r == LAST_IDX) begin
          res_st_nxt = ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_L0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      ret_r       <= S_IDLE;
      reinit_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      cfg_base_r  <= HEAP_BASE_RST;
      cfg_size_r  <= HEAP_SIZE_RST;
      pb_r        <= HEAP_BASE_RST;
      ps_r        <= HEAP_SIZE_RST;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      reinit_r    <= reinit_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_base_r  <= cfg_base_nxt;
      cfg_size_r  <= cfg_size_nxt;
      pb_r        <= pb_nxt;
      ps_r        <= ps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sz_r <= sz_nxt;  key_r <= key_nxt;  h_r <= h_nxt;  idx_r <= idx_nxt;
    lk_addr_r <= lk_addr_nxt;  cur_r <= cur_nxt;  s_r <= s_nxt;
    back_r <= back_nxt;  after_r <= after_nxt;
    sub_i_r <= sub_i_nxt;  sub_p_r <= sub_p_nxt;  sub_n_r <= sub_n_nxt;
    w_addr_r <= w_addr_nxt;  w_size_r <= w_size_nxt;  a0_r <= a0_nxt;  s0_r <= s0_nxt;
    nda_r <= nda_nxt;  nds_r <= nds_nxt;  la_r <= la_nxt;  ls_r <= ls_nxt;  rs_r <= rs_nxt;
    nd_r <= nd_nxt;  m_r <= m_nxt;  left_r <= left_nxt;  right_r <= right_nxt;
    lf_r <= lf_nxt;  rf_r <= rf_nxt;
    res_st_r <= res_st_nxt;  res_h_r <= res_h_nxt;  res_a_r <= res_a_nxt;  res_s_r <= res_s_nxt;
    out_st_r <= out_st_nxt;  out_h_r <= out_h_nxt;  out_a_r <= out_a_nxt;  out_s_r <= out_s_nxt;
  end

  `BFA_ASSERT_NEVER(a_lnk_rw_same_cycle, lnk_we && lnk_re, "link memory read and write together")
  `BFA_ASSERT(a_out_from_resp, $rose(out_valid_r) |-> $past(state_r == S_RESP), "result loaded outside response")
  `BFA_ASSERT(a_sweep_range, (state_r == S_SWEEP) |-> (sw_idx <= HEAD_UNUSED), "sweep index out of range")
  `BFA_ASSERT(a_walk_on_free_list, (state_r == S_WK1 && !back_r) |-> (cur_r != HEAD_ALLOC && cur_r != HEAD_UNUSED), "forward walk left the free list")
  `BFA_ASSERT(a_unlink_descriptor, (state_r == S_UN0) |-> (sub_i_r < HEAD_ALLOC), "unlink targets a list head")

endmodule

`default_nettype wire
